### rtl/nibble_command_chunk_receiver_defines.svh
// Assertion macros shared by the nibble command chunk receiver RTL.
`ifndef NIBBLE_COMMAND_CHUNK_RECEIVER_DEFINES_SVH
`define NIBBLE_COMMAND_CHUNK_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define NCR_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define NCR_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`else

`define NCR_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define NCR_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

### rtl/ncr_pkg.sv
// Types and constants of the nibble command chunk receiver.
`default_nettype none

package ncr_pkg;

    localparam int BYTE_W     = 8;
    localparam int NIBBLE_W   = 4;
    localparam int PORT_W     = 2;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int REG_COUNT  = 4;

    typedef logic [NIBBLE_W-1:0] cmd_t;

    localparam cmd_t CMD_REQUEST_IDS  = 4'd1;
    localparam cmd_t CMD_SET_PORT     = 4'd2;
    localparam cmd_t CMD_SET_ROW      = 4'd3;
    localparam cmd_t CMD_SET_CHUNK    = 4'd4;
    localparam cmd_t CMD_NIBBLE_FIRST = 4'd5;
    localparam cmd_t CMD_NIBBLE_LAST  = 4'd12;
    localparam cmd_t CMD_WRITE        = 4'd13;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Latched target of a chunk write.
    typedef struct packed {
        logic [PORT_W-1:0]   port;
        logic [NIBBLE_W-1:0] row;
        logic [NIBBLE_W-1:0] chunk;
        logic [WORD_W-1:0]   word;
    } target_t;

    // One result transaction.
    typedef struct packed {
        logic                kind;
        logic [PORT_W-1:0]   write_port;
        logic [NIBBLE_W-1:0] write_row;
        logic [NIBBLE_W-1:0] write_chunk;
        logic [WORD_W-1:0]   write_word;
        logic [BYTE_W-1:0]   reply_byte;
        logic                last;
    } result_t;

endpackage

`default_nettype wire

### rtl/ncr_if.sv
// Channel interfaces: command bytes in, results out, configuration writes.
`default_nettype none

interface ncr_byte_if
    import ncr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ncr_result_if
    import ncr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [PORT_W-1:0]   write_port;
    logic [NIBBLE_W-1:0] write_row;
    logic [NIBBLE_W-1:0] write_chunk;
    logic [WORD_W-1:0]   write_word;
    logic [BYTE_W-1:0]   reply_byte;
    logic                last;

    modport source (output valid, output kind, output write_port, output write_row,
                    output write_chunk, output write_word, output reply_byte,
                    output last, input ready);
    modport sink   (input valid, input kind, input write_port, input write_row,
                    input write_chunk, input write_word, input reply_byte,
                    input last, output ready);
endinterface

interface ncr_cfg_if
    import ncr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [NIBBLE_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/nibble_command_chunk_receiver.sv
// Top level of the nibble command chunk receiver.
// Each rx transaction carries one command byte: high nibble command, low
// nibble operand. Commands 2, 3 and 4 latch the port, row and chunk index;
// commands 5..12 place the operand as nibble (cmd-5) of the chunk word (nibbles
// at or past CHUNK_NIBBLES are dropped); command 13 sends one chunk-write
// transaction on tx; command 1 sends PORTS reply transactions, one per port,
// holding (port+1) in the high nibble and the configured panel id in the low
// nibble, with last set on the final one. Commands 0, 14 and 15 are dropped.
// Throughput is one byte per cycle while the result register is free; a
// request-ids byte holds the decode stage until the reply counter has fed
// all PORTS replies to the single result register. Panel ids are written
// through cfg (index 0..PORTS-1, 4-bit data); cfg is always ready. cfg
// is to be written only while no byte is in flight; nothing enforces it.
`default_nettype none

`include "nibble_command_chunk_receiver_defines.svh"

module nibble_command_chunk_receiver
    import ncr_pkg::*;
#(
    parameter int PORTS         = 4,
    parameter int CHUNK_NIBBLES = 8
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ncr_byte_if.sink      rx,
    ncr_result_if.source  tx,
    ncr_cfg_if.sink       cfg
);

    localparam int CNT_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    // Input register: holds the byte being decoded.
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;

    // Reply counter: walks the ports of a request-ids byte.
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg, res_next;

    logic [NIBBLE_W-1:0] panel_id_reg [PORTS];

    cmd_t    cmd;
    logic    consume;
    logic    load;
    logic    out_free;
    logic    rx_fire;
    logic    cnt_last;
    target_t target;

    assign cmd      = in_byte_reg[BYTE_W-1:NIBBLE_W];
    assign out_free = !out_valid_reg || tx.ready;
    assign cnt_last = (cnt_reg == CNT_W'(PORTS - 1));
    assign rx.ready = !in_valid_reg || consume;
    assign rx_fire  = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    // Decode: retire the held byte, and load a result when the result
    // register is free.
    always_comb
    begin
        consume  = 1'b0;
        load     = 1'b0;
        cnt_next = cnt_reg;
        res_next = '0;
        if (in_valid_reg)
        begin
            unique case (cmd) inside
                CMD_REQUEST_IDS:
                begin
                    if (out_free)
                    begin
                        load                = 1'b1;
                        res_next.kind       = KIND_REPLY;
                        res_next.reply_byte = {NIBBLE_W'(cnt_reg) + NIBBLE_W'(1),
                                               panel_id_reg[cnt_reg]};
                        res_next.last       = cnt_last;
                        if (cnt_last)
                        begin
                            consume  = 1'b1;
                            cnt_next = '0;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                end
                CMD_WRITE:
                begin
                    if (out_free)
                    begin
                        load                 = 1'b1;
                        consume              = 1'b1;
                        res_next.kind        = KIND_WRITE;
                        res_next.write_port  = target.port;
                        res_next.write_row   = target.row;
                        res_next.write_chunk = target.chunk;
                        res_next.write_word  = target.word;
                        res_next.last        = 1'b1;
                    end
                end
                default:
                begin
                    // latch and nibble commands retire at once; others drop
                    consume = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        if (rx_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    // Panel id registers; indexes past the port count are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                panel_id_reg[i] <= '0;
            end
        end
        else if (cfg.valid && cfg.ready && (cfg.index < CFG_IDX_W'(PORTS)))
        begin
            panel_id_reg[cfg.index[CNT_W-1:0]] <= cfg.data;
        end
    end

    // Latches advance only when their byte retires, so a write sees every
    // earlier latch and nibble command.
    ncr_target #(
        .CHUNK_NIBBLES (CHUNK_NIBBLES)
    ) u_target (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (consume),
        .cmd_byte (in_byte_reg),
        .target   (target)
    );

    assign tx.valid       = out_valid_reg;
    assign tx.kind        = res_reg.kind;
    assign tx.write_port  = res_reg.write_port;
    assign tx.write_row   = res_reg.write_row;
    assign tx.write_chunk = res_reg.write_chunk;
    assign tx.write_word  = res_reg.write_word;
    assign tx.reply_byte  = res_reg.reply_byte;
    assign tx.last        = res_reg.last;

    // Final reply of a request always names the highest port.
    `NCR_ASSERT_IMPLIES(a_last_reply_port, clk, rst_n,
        tx.valid && (tx.kind == KIND_REPLY) && tx.last,
        tx.reply_byte[BYTE_W-1:NIBBLE_W] == NIBBLE_W'(PORTS))
    // A chunk write is always the only result of its byte.
    `NCR_ASSERT_IMPLIES(a_write_is_last, clk, rst_n,
        tx.valid && (tx.kind == KIND_WRITE), tx.last)
    // The reply counter runs only while a request-ids byte is held.
    `NCR_ASSERT_IMPLIES(a_cnt_owner, clk, rst_n,
        cnt_reg != '0, in_valid_reg && (cmd == CMD_REQUEST_IDS))
    // A loaded result is presented in the next cycle.
    `NCR_ASSERT_NEXT(a_load_shows, clk, rst_n, load, tx.valid)

endmodule

`default_nettype wire

### rtl/ncr_target.sv
// Latches for port, row, chunk index and the assembled chunk word.
`default_nettype none

module ncr_target
    import ncr_pkg::*;
#(
    parameter int CHUNK_NIBBLES = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              upd,
    input  wire logic [BYTE_W-1:0] cmd_byte,
    output target_t                target
);

    localparam int STORE_W = CHUNK_NIBBLES * NIBBLE_W;

    logic [PORT_W-1:0]   port_reg,  port_next;
    logic [NIBBLE_W-1:0] row_reg,   row_next;
    logic [NIBBLE_W-1:0] chunk_reg, chunk_next;
    logic [STORE_W-1:0]  word_reg,  word_next;

    cmd_t                cmd;
    logic [NIBBLE_W-1:0] opnd;
    logic [NIBBLE_W-1:0] nib_idx;

    assign cmd     = cmd_byte[BYTE_W-1:NIBBLE_W];
    assign opnd    = cmd_byte[NIBBLE_W-1:0];
    assign nib_idx = cmd - CMD_NIBBLE_FIRST;

    always_comb
    begin
        port_next  = port_reg;
        row_next   = row_reg;
        chunk_next = chunk_reg;
        word_next  = word_reg;
        if (upd)
        begin
            unique case (cmd) inside
                CMD_SET_PORT:  port_next  = opnd[PORT_W-1:0];
                CMD_SET_ROW:   row_next   = opnd;
                CMD_SET_CHUNK: chunk_next = opnd;
                [CMD_NIBBLE_FIRST:CMD_NIBBLE_LAST]:
                begin
                    // nibbles past the stored width are dropped
                    for (int i = 0; i < CHUNK_NIBBLES; i++)
                    begin
                        if (nib_idx == NIBBLE_W'(i))
                        begin
                            word_next[i*NIBBLE_W +: NIBBLE_W] = opnd;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_reg  <= '0;
            row_reg   <= '0;
            chunk_reg <= '0;
            word_reg  <= '0;
        end
        else
        begin
            port_reg  <= port_next;
            row_reg   <= row_next;
            chunk_reg <= chunk_next;
            word_reg  <= word_next;
        end
    end

    assign target.port  = port_reg;
    assign target.row   = row_reg;
    assign target.chunk = chunk_reg;
    assign target.word  = WORD_W'(word_reg);

endmodule

`default_nettype wire
